>>> design/pbspd_pkg.sv
// package for the ordered packet buffer: sizes, codes and the
// controller/datapath interface structs; depends on nothing
package pbspd_pkg;

  localparam int DEPTH = 64;
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = 66;

  typedef enum logic [2:0] {
    CMD_ENQ = 3'd0,
    CMD_DEQ_ACT = 3'd1,
    CMD_DEQ_INACT = 3'd2,
    CMD_DROP = 3'd3,
    CMD_FIND = 3'd4
  } cmd_code_t;

  localparam logic [1:0] ST_NOT_FWD = 2'd0;
  localparam logic [1:0] ST_INACT_FWD = 2'd1;
  localparam logic [1:0] ST_ACT_FWD = 2'd2;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic scan_go;
    logic compact_go;
    logic append;
    logic respond;
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic pass_done;
    logic is_enq;
    logic is_drop;
    logic is_known;
    logic dup;
    logic any_seen;
    logic full;
  } dp_status_t;

endpackage

>>> design/pbspd_ctrl.sv
// controller state machine for the packet buffer
// depends on pbspd_pkg
module pbspd_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  pbspd_pkg::dp_status_t st,
  output pbspd_pkg::dp_cmd_t    dc
);
  import pbspd_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_LAUNCH  = 6'b000010,
    S_SCAN    = 6'b000100,
    S_DECIDE  = 6'b001000,
    S_COMPACT = 6'b010000,
    S_REPLY   = 6'b100000
  } state_t;

  state_t state, state_next;
  logic   do_append;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    dc = '0;
    do_append = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          dc.load = 1'b1;
          state_next = S_LAUNCH;
        end
      end
      S_LAUNCH: begin
        if (st.is_drop) begin
          dc.compact_go = 1'b1;
          state_next = S_COMPACT;
        end else if (st.is_known) begin
          dc.scan_go = 1'b1;
          state_next = S_SCAN;
        end else begin
          state_next = S_REPLY;
        end
      end
      S_SCAN: begin
        if (st.pass_done) begin
          state_next = st.is_enq ? S_DECIDE : S_REPLY;
        end
      end
      S_DECIDE: begin
        if (st.dup) begin
          state_next = S_REPLY;
        end else if (st.full) begin
          if (st.any_seen) begin
            dc.compact_go = 1'b1;
            state_next = S_COMPACT;
          end else begin
            state_next = S_REPLY;
          end
        end else begin
          do_append = 1'b1;
          state_next = S_REPLY;
        end
      end
      S_COMPACT: begin
        if (st.pass_done) begin
          state_next = st.is_enq ? S_DECIDE : S_REPLY;
        end
      end
      S_REPLY: begin
        dc.respond = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
    dc.append = do_append;
  end

endmodule

>>> design/pbspd_dp.sv
// datapath: entry memory, scan/compaction pass engine, count and result
// registers; depends on pbspd_pkg
module pbspd_dp (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [2:0]            cmd,
  input  logic [31:0]           packet_id,
  input  logic [31:0]           destination,
  input  logic                  cfg_we,
  input  logic [6:0]            cfg_data,
  input  pbspd_pkg::dp_cmd_t    dc,
  output pbspd_pkg::dp_status_t st,
  output logic                  result_valid,
  output logic                  ok,
  output logic [31:0]           out_packet_id,
  output logic [31:0]           out_destination,
  output logic                  evicted,
  output logic [6:0]            occupancy
);
  import pbspd_pkg::*;

  logic [EW-1:0] mem [DEPTH];
  logic [EW-1:0] rdata;
  logic [6:0]    max_entries;
  logic [CW-1:0] count;
  logic [2:0]    req_cmd;
  logic [31:0]   req_id;
  logic [31:0]   req_dst;
  logic          active;
  logic          mode_compact;
  logic [CW-1:0] rptr;
  logic [CW-1:0] wptr;
  logic          dvalid;
  logic [AW-1:0] didx;
  logic          dup;
  logic          hit;
  logic          ev;
  logic          appended;
  logic [2:0]    seen;
  logic [AW-1:0] first [3];
  logic [AW-1:0] victim;
  logic [31:0]   hit_id;
  logic [31:0]   hit_dst;
  logic [CW-1:0] limit;
  logic          pass_done;
  logic [31:0]   d_id;
  logic [31:0]   d_dst;
  logic [1:0]    d_st;
  logic          d_hit;
  logic          keep;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [EW-1:0] wr_data;
  logic          issue;

  assign d_id  = rdata[65:34];
  assign d_dst = rdata[33:2];
  assign d_st  = rdata[1:0];

  // effective limit clamped to 1..DEPTH
  always_comb begin
    if (max_entries == 7'd0) begin
      limit = CW'(1);
    end else if (CW'(max_entries) > CW'(DEPTH) || 32'(max_entries) > DEPTH) begin
      limit = CW'(DEPTH);
    end else begin
      limit = CW'(max_entries);
    end
  end

  assign issue     = active && (rptr < count);
  assign pass_done = active && !issue && !dvalid;

  // match for the dequeue and find scans
  always_comb begin
    d_hit = 1'b0;
    if (d_dst == req_dst) begin
      case (req_cmd)
        CMD_DEQ_ACT:   d_hit = (d_st == ST_NOT_FWD) || (d_st == ST_INACT_FWD);
        CMD_DEQ_INACT: d_hit = (d_st == ST_NOT_FWD);
        CMD_FIND:      d_hit = 1'b1;
        default:       d_hit = 1'b0;
      endcase
    end
  end

  assign keep = (req_cmd == CMD_DROP) ? (d_dst != req_dst) : (didx != victim);

  // single memory write port
  always_comb begin
    wr_en = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    if (dc.append) begin
      wr_en = 1'b1;
      wr_addr = count[AW-1:0];
      wr_data = {req_id, req_dst, ST_NOT_FWD};
    end else if (dvalid && mode_compact && keep) begin
      wr_en = 1'b1;
      wr_addr = wptr[AW-1:0];
      wr_data = rdata;
    end else if (dvalid && !mode_compact && d_hit && !hit &&
                 (req_cmd == CMD_DEQ_ACT || req_cmd == CMD_DEQ_INACT)) begin
      wr_en = 1'b1;
      wr_addr = didx;
      wr_data = {d_id, d_dst, (req_cmd == CMD_DEQ_ACT) ? ST_ACT_FWD : ST_INACT_FWD};
    end
  end

  // entry memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (issue) begin
      rdata <= mem[rptr[AW-1:0]];
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_entries <= 7'd64;
    end else if (cfg_we) begin
      max_entries <= cfg_data;
    end
  end

  // request latch
  always_ff @(posedge clk) begin
    if (dc.load) begin
      req_cmd <= cmd;
      req_id  <= packet_id;
      req_dst <= destination;
    end
  end

  // pass engine, flags and count
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      dvalid <= 1'b0;
      count  <= '0;
    end else begin
      dvalid <= issue;
      if (issue) begin
        didx <= rptr[AW-1:0];
        rptr <= rptr + CW'(1);
      end
      if (pass_done) begin
        active <= 1'b0;
        if (mode_compact) begin
          count <= wptr;
        end
      end
      if (dc.load) begin
        dup <= 1'b0;
        hit <= 1'b0;
        ev <= 1'b0;
        appended <= 1'b0;
        seen <= 3'b000;
        hit_id <= '0;
        hit_dst <= '0;
      end
      if (dc.scan_go || dc.compact_go) begin
        active <= 1'b1;
        mode_compact <= dc.compact_go;
        rptr <= '0;
        wptr <= '0;
      end
      // victim by class priority at eviction start
      if (dc.compact_go && req_cmd == CMD_ENQ) begin
        ev <= 1'b1;
        if (seen[2]) begin
          victim <= first[2];
        end else if (seen[1]) begin
          victim <= first[1];
        end else begin
          victim <= first[0];
        end
      end
      if (dvalid && mode_compact && keep) begin
        wptr <= wptr + CW'(1);
      end
      if (dvalid && !mode_compact) begin
        if (d_id == req_id && d_dst == req_dst) begin
          dup <= 1'b1;
        end
        if (d_st != 2'd3 && !seen[d_st]) begin
          seen[d_st] <= 1'b1;
          first[d_st] <= didx;
        end
        if (d_hit && !hit) begin
          hit <= 1'b1;
          if (req_cmd == CMD_DEQ_ACT || req_cmd == CMD_DEQ_INACT) begin
            hit_id <= d_id;
            hit_dst <= d_dst;
          end
        end
      end
      if (dc.append) begin
        count <= count + CW'(1);
        appended <= 1'b1;
      end
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= dc.respond;
    end
    if (dc.respond) begin
      case (req_cmd) inside
        CMD_ENQ:                              ok <= appended;
        CMD_DROP:                             ok <= 1'b1;
        CMD_DEQ_ACT, CMD_DEQ_INACT, CMD_FIND: ok <= hit;
        default:                              ok <= 1'b0;
      endcase
      out_packet_id   <= hit_id;
      out_destination <= hit_dst;
      evicted         <= ev;
      occupancy       <= 7'(count);
    end
  end

  assign st.pass_done = pass_done;
  assign st.is_enq    = (req_cmd == CMD_ENQ);
  assign st.is_drop   = (req_cmd == CMD_DROP);
  assign st.is_known  = (req_cmd == CMD_ENQ) || (req_cmd == CMD_DEQ_ACT) ||
                        (req_cmd == CMD_DEQ_INACT) || (req_cmd == CMD_FIND);
  assign st.dup       = dup;
  assign st.any_seen  = |seen;
  // at most one eviction per enqueue, then the append follows
  assign st.full      = (count >= limit) && !ev;

endmodule

>>> design/packet_buffer_status_priority_drop.sv
// Ordered packet buffer with class-priority eviction.
// A request is taken when start is high and busy is low: cmd, packet_id and
// destination. Commands: enqueue, dequeue for an active or inactive route,
// drop all for a destination, find. Busy stays high until the reply.
// The reply appears for one cycle with result_valid high: ok,
// out_packet_id, out_destination, evicted, occupancy. It cannot be held off.
// The limit register max_entries is written over cfg_valid/cfg_ready/
// cfg_data (ready always high). The user must write it only between
// requests; the block itself does not enforce this. Each pass walks the
// entry memory through its single read port, one entry a cycle. Find and
// dequeue make one scan pass, drop one compaction pass; enqueue makes a
// scan pass, plus a compaction pass when an eviction compacts the memory.
// One request at a time.
// Reset clears the count (buffer empty) and sets max_entries to 64; memory
// contents need no clearing.
// Depends on pbspd_pkg, pbspd_ctrl, pbspd_dp.
module packet_buffer_status_priority_drop (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  cmd,
  input  logic [31:0] packet_id,
  input  logic [31:0] destination,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data,
  output logic        result_valid,
  output logic        ok,
  output logic [31:0] out_packet_id,
  output logic [31:0] out_destination,
  output logic        evicted,
  output logic [6:0]  occupancy
);
  import pbspd_pkg::*;

  dp_cmd_t    dc;
  dp_status_t st;
  logic       ctrl_start;

  assign cfg_ready  = 1'b1;
  assign ctrl_start = start && !busy;

  // controller
  pbspd_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (ctrl_start),
    .busy  (busy),
    .st    (st),
    .dc    (dc)
  );

  // datapath
  pbspd_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .packet_id       (packet_id),
    .destination     (destination),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_data        (cfg_data),
    .dc              (dc),
    .st              (st),
    .result_valid    (result_valid),
    .ok              (ok),
    .out_packet_id   (out_packet_id),
    .out_destination (out_destination),
    .evicted         (evicted),
    .occupancy       (occupancy)
  );

endmodule

>>> design/pbspd_checker.sv
// port-level checks for the packet buffer and the bind that attaches them
// depends on packet_buffer_status_priority_drop
module pbspd_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        result_valid,
  input logic        ok,
  input logic [31:0] out_packet_id,
  input logic [31:0] out_destination,
  input logic [6:0]  occupancy
);

  // a taken request keeps the block busy
  a_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("request not held busy");

  // the reply lasts one cycle
  a_reply_end: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid) else $error("reply not single");

  // reply shows once the block is idle again
  a_reply_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !busy) else $error("reply while busy");

  // no payload on a miss
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !ok |-> out_packet_id == 32'd0 && out_destination == 32'd0)
    else $error("payload on miss");

  // occupancy bounded by depth
  a_occ: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> occupancy <= 7'd64) else $error("occupancy over depth");

endmodule

bind packet_buffer_status_priority_drop pbspd_checker u_pbspd_checker (
  .clk             (clk),
  .rst             (rst),
  .start           (start),
  .busy            (busy),
  .result_valid    (result_valid),
  .ok              (ok),
  .out_packet_id   (out_packet_id),
  .out_destination (out_destination),
  .occupancy       (occupancy)
);
